/* hdl/clce_pkg.sv */
// Package: constants, codes and types shared by the list cursor engine.
`timescale 1ns / 1ps
`default_nettype none
package clce_pkg;
    localparam int PoolNodes = 256;
    localparam int IdxW = $clog2(PoolNodes);
    localparam int CntW = $clog2(PoolNodes + 1);
    localparam int ValW = 32;
    localparam int LenW = 9;

    typedef enum logic [2:0] {
        CMD_INS_BEFORE = 3'd0,
        CMD_INS_AFTER  = 3'd1,
        CMD_DEL_AFTER  = 3'd2,
        CMD_DEL_BEFORE = 3'd3,
        CMD_DEL_CUR    = 3'd4,
        CMD_CLEAR      = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_ONE   = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_RD_NB,
        S_WAIT_NB,
        S_RD_NN,
        S_WAIT_NN,
        S_WR_A,
        S_WR_B,
        S_RD_VAL,
        S_WAIT_VAL,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [2:0]        command;
        logic signed [31:0] value;
    } t_cmd_item;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] cursor_value;
        logic [LenW-1:0]    length;
        logic               list_empty;
    } t_res_item;
endpackage
`default_nettype wire

/* hdl/clce_if.sv */
// Valid/ready channel interfaces for commands and results.
`timescale 1ns / 1ps
`default_nettype none
interface clce_cmd_if;
    import clce_pkg::*;
    logic      valid;
    logic      ready;
    t_cmd_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface clce_res_if;
    import clce_pkg::*;
    logic      valid;
    logic      ready;
    t_res_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hdl/circular_list_cursor_engine_core.sv */
// Top level: list cursor engine, sequencer over the pool memories.
//  channel | dir | handshake     | payload
//  cmd     | in  | valid / ready | command, value
//  res     | out | valid / ready | status, cursor_value, length, list_empty
// Steps per command follow the dependent accesses to the single-port memories:
// a status-only answer goes straight out; clear or an unused code reads the
// cursor value; removing the only node writes first; insert or remove-current
// reads the neighbours first; unlinking a neighbour also reads the far one.
// The next command is taken once the result has been taken.
// Reset is synchronous and clears the control state only; the memories hold
// no reset value; cursor_value is forced to zero while the list is empty.
`timescale 1ns / 1ps
`default_nettype none
module circular_list_cursor_engine_core (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    clce_cmd_if.sink  i_cmd,
    clce_res_if.source o_res
);
    import clce_pkg::*;

    t_state r_state, n_state;
    logic [2:0]      r_cmd;
    logic [ValW-1:0] r_val;
    logic [CntW-1:0] r_free_top, r_high, r_count;
    logic [IdxW-1:0] r_cur, r_new, r_nb, r_nn;
    logic [1:0]      r_status;
    logic [ValW-1:0] r_out_val;
    logic            r_fs_pop;

    // memory ports
    logic            nx_we, pv_we, vl_we, fs_we;
    logic [IdxW-1:0] nx_a, pv_a, vl_a, fs_a;
    logic [IdxW-1:0] nx_wd, pv_wd, nx_rd, pv_rd, fs_wd, fs_rd;
    logic [ValW-1:0] vl_rd;

    clce_ram #(.Width(IdxW), .Depth(PoolNodes)) u_next (
        .i_clk(i_clk), .i_we(nx_we), .i_addr(nx_a), .i_wdata(nx_wd), .o_rdata(nx_rd));
    clce_ram #(.Width(IdxW), .Depth(PoolNodes)) u_prev (
        .i_clk(i_clk), .i_we(pv_we), .i_addr(pv_a), .i_wdata(pv_wd), .o_rdata(pv_rd));
    clce_ram #(.Width(ValW), .Depth(PoolNodes)) u_val (
        .i_clk(i_clk), .i_we(vl_we), .i_addr(vl_a), .i_wdata(r_val), .o_rdata(vl_rd));
    clce_ram #(.Width(IdxW), .Depth(PoolNodes)) u_free (
        .i_clk(i_clk), .i_we(fs_we), .i_addr(fs_a), .i_wdata(fs_wd), .o_rdata(fs_rd));

    logic is_ins, is_del_nb, can_take, accept, nb_is_prev;
    assign is_ins    = (r_cmd == CMD_INS_BEFORE) || (r_cmd == CMD_INS_AFTER);
    assign is_del_nb = (r_cmd == CMD_DEL_AFTER) || (r_cmd == CMD_DEL_BEFORE);
    assign can_take  = (r_free_top != '0) || (r_high < CntW'(PoolNodes));
    assign accept    = i_cmd.valid && i_cmd.ready;
    // which neighbour of the cursor is kept in r_nb
    assign nb_is_prev = (r_cmd == CMD_INS_BEFORE) || (r_cmd == CMD_DEL_BEFORE);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (accept) n_state = S_DECIDE;
            S_DECIDE: begin
                if (is_ins) begin
                    // the popped free node lands in r_new during S_RD_NB
                    if (!can_take) n_state = S_OUT;
                    else n_state = S_RD_NB;
                end else if (is_del_nb || r_cmd == CMD_DEL_CUR) begin
                    if (r_count == '0) n_state = S_OUT;
                    else if (r_count == CntW'(1)) begin
                        n_state = (r_cmd == CMD_DEL_CUR) ? S_WR_A : S_OUT;
                    end else n_state = S_RD_NB;
                end else begin
                    n_state = S_RD_VAL;
                end
            end
            S_RD_NB:   n_state = S_WAIT_NB;
            S_WAIT_NB: n_state = is_del_nb ? S_RD_NN : S_WR_A;
            S_RD_NN:   n_state = S_WAIT_NN;
            S_WAIT_NN: n_state = S_WR_A;
            S_WR_A:    n_state = S_WR_B;
            S_WR_B:    n_state = S_RD_VAL;
            S_RD_VAL:  n_state = S_WAIT_VAL;
            S_WAIT_VAL: n_state = S_OUT;
            S_OUT:     if (o_res.ready) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // victim node of a delete, and its far neighbours
    logic [IdxW-1:0] victim, vp, vq;
    always_comb begin
        if (is_del_nb) begin
            victim = r_nb;
            vp = (r_cmd == CMD_DEL_AFTER) ? r_cur : r_nn;
            vq = (r_cmd == CMD_DEL_AFTER) ? r_nn : r_cur;
        end else begin
            victim = r_cur;
            vp = r_nn;
            vq = r_nb;
        end
    end

    // memory controls
    always_comb begin
        nx_we = 1'b0; pv_we = 1'b0; vl_we = 1'b0; fs_we = 1'b0;
        nx_a = r_cur; pv_a = r_cur; vl_a = r_cur;
        nx_wd = r_new; pv_wd = r_new;
        fs_a = IdxW'(r_free_top - CntW'(1)); fs_wd = victim;
        case (r_state)
            S_RD_NB: begin
                nx_a = r_cur; pv_a = r_cur;
            end
            S_RD_NN: begin
                nx_a = r_nb; pv_a = r_nb;
            end
            S_WR_A: begin
                if (is_ins) begin
                    vl_we = 1'b1; vl_a = r_new;
                    nx_we = 1'b1; pv_we = 1'b1; nx_a = r_new; pv_a = r_new;
                    if (r_count == '0) begin
                        nx_wd = r_new; pv_wd = r_new;
                    end else if (r_cmd == CMD_INS_BEFORE) begin
                        nx_wd = r_cur; pv_wd = r_nb;
                    end else begin
                        nx_wd = r_nb; pv_wd = r_cur;
                    end
                end else begin
                    // join neighbours, push victim
                    nx_we = (r_count != CntW'(1)); nx_a = vp; nx_wd = vq;
                    pv_we = (r_count != CntW'(1)); pv_a = vq; pv_wd = vp;
                    fs_we = (r_free_top < CntW'(PoolNodes));
                    fs_a = IdxW'(r_free_top); fs_wd = victim;
                end
            end
            S_WR_B: begin
                if (is_ins && r_count != '0) begin
                    if (r_cmd == CMD_INS_BEFORE) begin
                        nx_we = 1'b1; nx_a = r_nb; nx_wd = r_new;
                        pv_we = 1'b1; pv_a = r_cur; pv_wd = r_new;
                    end else begin
                        nx_we = 1'b1; nx_a = r_cur; nx_wd = r_new;
                        pv_we = 1'b1; pv_a = r_nb; pv_wd = r_new;
                    end
                end
            end
            S_RD_VAL: vl_a = r_cur;
            default: ;
        endcase
    end

    // outputs
    always_comb begin
        i_cmd.ready = (r_state == S_IDLE);
        o_res.valid = (r_state == S_OUT);
        o_res.data.status = r_status;
        o_res.data.cursor_value = (r_count == '0) ? '0 : r_out_val;
        o_res.data.length = LenW'(r_count);
        o_res.data.list_empty = (r_count == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_free_top <= '0; r_high <= '0; r_count <= '0; r_cur <= '0;
            r_status <= ST_OK; r_fs_pop <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fs_pop <= 1'b0;
            if (r_fs_pop) r_new <= fs_rd;
            case (r_state)
                S_IDLE: if (accept) begin
                    r_cmd <= i_cmd.data.command;
                    r_val <= i_cmd.data.value;
                    r_status <= ST_OK;
                end
                S_DECIDE: begin
                    if (is_ins) begin
                        if (!can_take) r_status <= ST_FULL;
                        else if (r_free_top != '0) begin
                            r_free_top <= r_free_top - CntW'(1);
                            r_fs_pop <= 1'b1;
                        end else begin
                            r_new <= IdxW'(r_high);
                            r_high <= r_high + CntW'(1);
                        end
                    end else if (is_del_nb || r_cmd == CMD_DEL_CUR) begin
                        if (r_count == '0) r_status <= ST_EMPTY;
                        else if (r_count == CntW'(1) && is_del_nb) r_status <= ST_ONE;
                    end else if (r_cmd == CMD_CLEAR) begin
                        if (r_count == '0) r_status <= ST_EMPTY;
                        else begin
                            r_free_top <= '0; r_high <= '0; r_count <= '0; r_cur <= '0;
                        end
                    end
                end
                S_WAIT_NB: begin
                    r_nb <= nb_is_prev ? pv_rd : nx_rd;
                    // remove-current also needs the cursor's predecessor
                    if (r_cmd == CMD_DEL_CUR) r_nn <= pv_rd;
                end
                // far neighbour of the node being unlinked
                S_WAIT_NN: r_nn <= (r_cmd == CMD_DEL_AFTER) ? nx_rd : pv_rd;
                S_WR_A: begin
                    if (!is_ins) begin
                        if (r_free_top < CntW'(PoolNodes)) r_free_top <= r_free_top + CntW'(1);
                        if (r_count == CntW'(1)) begin
                            r_count <= '0; r_cur <= '0;
                        end else begin
                            r_count <= r_count - CntW'(1);
                            if (r_cmd == CMD_DEL_CUR) r_cur <= r_nb;
                        end
                    end
                end
                // cursor moves only after the old cursor's link is written
                S_WR_B: begin
                    if (is_ins) begin
                        r_cur <= r_new;
                        r_count <= r_count + CntW'(1);
                    end
                end
                S_WAIT_VAL: r_out_val <= vl_rd;
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

/* hdl/clce_ram.sv */
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module clce_ram #(
    parameter int Width = 8,
    parameter int Depth = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_addr,
    input  wire logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]              o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire
